// ----- src/kpert_pkg.sv -----
// types, constants and key code decode shared by the key edge/repeat table
package kpert_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int SLOT_BITS = $clog2(TABLE_DEPTH);
  localparam int COUNT_BITS_DEFAULT = 8;
  localparam int LIMIT_BITS = 8;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 8'd15;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [7:0] KEY_A = 8'h41;
  localparam logic [7:0] KEY_Z = 8'h5A;
  localparam logic [7:0] KEY_ARROW_FIRST = 8'h25;
  localparam logic [7:0] KEY_ARROW_LAST = 8'h28;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [7:0] KEY_ENTER = 8'h0D;

  localparam logic [SLOT_BITS-1:0] SLOT_ARROW_BASE = 5'd26;
  localparam logic [SLOT_BITS-1:0] SLOT_SPACE = 5'd30;
  localparam logic [SLOT_BITS-1:0] SLOT_ENTER = 5'd31;

  typedef struct packed {
    logic       req_type;
    logic [7:0] key_code;
    logic       key_down;
    logic       repeat_enable;
    logic       repeat_suppress;
  } req_t;

  typedef struct packed {
    logic fire;
    logic held;
    logic key_mapped;
  } res_t;

  typedef struct packed {
    logic                 mapped;
    logic [SLOT_BITS-1:0] slot;
  } slot_t;

  function automatic slot_t key_slot(input logic [7:0] code);
    slot_t s;
    s.mapped = 1'b1;
    s.slot = '0;
    if (code >= KEY_A && code <= KEY_Z) begin
      s.slot = SLOT_BITS'(code - KEY_A);
    end else if (code >= KEY_ARROW_FIRST && code <= KEY_ARROW_LAST) begin
      s.slot = SLOT_ARROW_BASE + SLOT_BITS'(code - KEY_ARROW_FIRST);
    end else if (code == KEY_SPACE) begin
      s.slot = SLOT_SPACE;
    end else if (code == KEY_ENTER) begin
      s.slot = SLOT_ENTER;
    end else begin
      s.mapped = 1'b0;
    end
    return s;
  endfunction

endpackage

// ----- src/kpert_entry_update.sv -----
// next-state and result logic for one table entry
module kpert_entry_update import kpert_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  req_t                  req,
  input  logic                  mapped,
  input  logic                  held_cur,
  input  logic                  latch_cur,
  input  logic [COUNT_BITS-1:0] count_cur,
  input  logic [LIMIT_BITS-1:0] limit,
  output logic                  write_en,
  output logic                  held_next,
  output logic                  latch_next,
  output logic [COUNT_BITS-1:0] count_next,
  output res_t                  res
);

  localparam int CMP_BITS = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  logic                  fire;
  logic [COUNT_BITS-1:0] cnt_start;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  over_limit;

  assign cnt_start = latch_cur ? count_cur : '0;
  assign cnt_inc = (cnt_start == COUNT_MAX) ? cnt_start : cnt_start + COUNT_BITS'(1);
  assign over_limit = CMP_BITS'(cnt_inc) > CMP_BITS'(limit);
  assign write_en = mapped && (req.req_type == REQ_UPDATE);

  always_comb begin
    held_next = held_cur;
    latch_next = latch_cur;
    count_next = count_cur;
    fire = 1'b0;
    if (req.req_type == REQ_UPDATE) begin
      if (req.key_down) begin
        held_next = 1'b1;
        if (req.repeat_enable) begin
          fire = !latch_cur;
          latch_next = 1'b1;
          count_next = cnt_start;
          if (!req.repeat_suppress) begin
            if (over_limit) begin
              latch_next = 1'b0;
              count_next = '0;
            end else begin
              count_next = cnt_inc;
            end
          end
        end else begin
          fire = 1'b1;
          count_next = '0;
        end
      end else begin
        held_next = 1'b0;
        latch_next = 1'b0;
      end
    end
  end

  assign res.fire = mapped && fire;
  assign res.held = mapped && held_next;
  assign res.key_mapped = mapped;

endmodule

// ----- src/key_press_edge_repeat_table.sv -----
// top level: per-key press edge detector with auto-repeat, 32-entry table
//
// input channel: in_valid / in_stall / in_data (update or query transaction)
// output channel: out_valid / out_stall / out_data, one result per transaction
// configuration: cfg_en writes cfg_data into repeat_limit at a clock edge; the user must raise it
// only while no transaction is in flight, which the block itself does not enforce
// an accepted transaction is registered, then the table entry is read,
// updated and written back while the result is registered
// throughput is one transaction per cycle while the receiver does not stall, as the
// flip-flop table is read, modified and written back as each result is registered
// when the receiver stalls, the result register holds and an empty input register
// still takes one more transaction, then in_stall rises
// synchronous reset clears every held flag, press latch and repeat counter,
// empties both registers and loads repeat_limit with 15
module key_press_edge_repeat_table import kpert_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output res_t                  out_data,
  input  logic                  cfg_en,
  input  logic [LIMIT_BITS-1:0] cfg_data
);

  logic                  s1_valid;
  req_t                  s1_req;
  logic                  advance;
  logic [LIMIT_BITS-1:0] repeat_limit;
  logic [TABLE_DEPTH-1:0] held_flags;
  logic [TABLE_DEPTH-1:0] press_latch;
  logic [COUNT_BITS-1:0]  repeat_count [TABLE_DEPTH];

  slot_t                 s1_slot;
  logic                  write_en;
  logic                  held_next;
  logic                  latch_next;
  logic [COUNT_BITS-1:0] count_next;
  res_t                  res_next;

  assign advance = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign s1_slot = key_slot(s1_req.key_code);

  kpert_entry_update #(
    .COUNT_BITS(COUNT_BITS)
  ) u_update (
    .req        (s1_req),
    .mapped     (s1_slot.mapped),
    .held_cur   (held_flags[s1_slot.slot]),
    .latch_cur  (press_latch[s1_slot.slot]),
    .count_cur  (repeat_count[s1_slot.slot]),
    .limit      (repeat_limit),
    .write_en   (write_en),
    .held_next  (held_next),
    .latch_next (latch_next),
    .count_next (count_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
      repeat_limit <= LIMIT_RESET;
      held_flags <= '0;
      press_latch <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        repeat_count[i] <= '0;
      end
    end else begin
      if (cfg_en) begin
        repeat_limit <= cfg_data;
      end
      if (!in_stall) begin
        s1_valid <= in_valid;
        if (in_valid) begin
          s1_req <= in_data;
        end
      end
      if (advance) begin
        out_valid <= s1_valid;
        if (s1_valid) begin
          out_data <= res_next;
          if (write_en) begin
            held_flags[s1_slot.slot] <= held_next;
            press_latch[s1_slot.slot] <= latch_next;
            repeat_count[s1_slot.slot] <= count_next;
          end
        end
      end
    end
  end

  // a press latch is only ever set by an update that also sets the held flag
  a_latch_needs_held: assert property (@(posedge clk) disable iff (rst)
    (press_latch & ~held_flags) == '0)
    else $error("press latch set on a key that is not held");

  a_fire_mapped_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fire |-> out_data.key_mapped && out_data.held)
    else $error("fire on an unmapped or released key");

  a_query_no_fire: assert property (@(posedge clk) disable iff (rst)
    s1_valid && advance && s1_req.req_type == REQ_QUERY |=> !out_data.fire)
    else $error("query transaction produced fire");

  a_stall_blocks_table: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(held_flags) && $stable(press_latch))
    else $error("table changed while result was stalled");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the key press edge and auto-repeat table
module tb;
  import kpert_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEFAULT;
  localparam logic [CNT_W-1:0] CNT_TOP = '1;
  localparam int DIR_N = 25;

  typedef struct packed {
    req_t req;
    logic typed;
    res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  res_t out_data;
  logic cfg_en = 1'b0;
  logic [LIMIT_BITS-1:0] cfg_data = '0;

  logic held_st [TABLE_DEPTH];
  logic latch_st [TABLE_DEPTH];
  logic [CNT_W-1:0] cnt_st [TABLE_DEPTH];
  logic [LIMIT_BITS-1:0] limit_st;

  res_t pending_results [$];
  int err_cnt = 0;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  dir_row_t dir_rows [DIR_N];

  key_press_edge_repeat_table u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_en    (cfg_en),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int table_slot(input logic [7:0] code);
    if (code >= KEY_A && code <= KEY_Z) return int'(code - KEY_A);
    if (code >= KEY_ARROW_FIRST && code <= KEY_ARROW_LAST) begin
      return int'(SLOT_ARROW_BASE) + int'(code - KEY_ARROW_FIRST);
    end
    if (code == KEY_SPACE) return int'(SLOT_SPACE);
    if (code == KEY_ENTER) return int'(SLOT_ENTER);
    return -1;
  endfunction

  function automatic logic [7:0] key_for_slot(input int s);
    if (s < 26) return KEY_A + 8'(s);
    if (s < 30) return KEY_ARROW_FIRST + 8'(s - 26);
    if (s == 30) return KEY_SPACE;
    return KEY_ENTER;
  endfunction

  function automatic logic [7:0] pick_key();
    if ($urandom_range(0, 99) < 12) return 8'($urandom);
    return key_for_slot($urandom_range(0, TABLE_DEPTH - 1));
  endfunction

  function automatic res_t next_key_result(input req_t r);
    res_t res;
    int s;
    res = '0;
    s = table_slot(r.key_code);
    if (s < 0) return res;
    res.key_mapped = 1'b1;
    if (r.req_type == REQ_UPDATE) begin
      if (r.key_down) begin
        held_st[s] = 1'b1;
        if (r.repeat_enable) begin
          if (!latch_st[s]) begin
            latch_st[s] = 1'b1;
            res.fire = 1'b1;
            cnt_st[s] = '0;
          end
          if (!r.repeat_suppress) begin
            if (cnt_st[s] != CNT_TOP) cnt_st[s] = cnt_st[s] + 1'b1;
            if (cnt_st[s] > limit_st) begin
              latch_st[s] = 1'b0;
              cnt_st[s] = '0;
            end
          end
        end else begin
          res.fire = 1'b1;
          cnt_st[s] = '0;
        end
      end else begin
        held_st[s] = 1'b0;
        latch_st[s] = 1'b0;
      end
    end
    res.held = held_st[s];
    return res;
  endfunction

  task automatic send_req(input req_t r, input logic typed, input res_t typed_res);
    res_t p;
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_gap_pct) begin
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = next_key_result(r);
    pending_results.push_back(typed ? typed_res : p);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_repeat_limit(input logic [LIMIT_BITS-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_en <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_en <= 1'b0;
    limit_st = v;
  endtask

  task automatic run_random(input int n_items, input int long_hold);
    req_t r;
    logic [7:0] code;
    logic en;
    logic sup;
    int sent;
    int pick;
    int len;
    int cap;
    sent = 0;
    if (long_hold > 0) begin
      r = '0;
      r.req_type = REQ_UPDATE;
      r.key_code = key_for_slot($urandom_range(0, TABLE_DEPTH - 1));
      r.key_down = 1'b1;
      r.repeat_enable = 1'b1;
      for (int i = 0; i < long_hold; i++) begin
        send_req(r, 1'b0, '0);
      end
      r.key_down = 1'b0;
      send_req(r, 1'b0, '0);
      sent = long_hold + 1;
    end
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_req(req_t'($urandom), 1'b0, '0);
        sent++;
      end else if (pick < 18) begin
        r = req_t'($urandom);
        r.req_type = REQ_QUERY;
        r.key_code = pick_key();
        send_req(r, 1'b0, '0);
        sent++;
      end else if (pick < 19) begin
        drain_results();
      end else begin
        // press, hold for a while, then usually release
        code = pick_key();
        en = ($urandom_range(0, 99) < 75);
        sup = ($urandom_range(0, 99) < 25);
        cap = (limit_st > 36) ? 40 : int'(limit_st) + 4;
        len = $urandom_range(1, cap);
        for (int i = 0; i < len; i++) begin
          r.req_type = REQ_UPDATE;
          r.key_code = code;
          r.key_down = 1'b1;
          r.repeat_enable = en;
          r.repeat_suppress = sup;
          if ($urandom_range(0, 99) < 5) r.repeat_enable = ~en;
          if ($urandom_range(0, 99) < 5) r.repeat_suppress = ~sup;
          if ($urandom_range(0, 99) < 8) r.key_code = pick_key();
          send_req(r, 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 99) < 85) begin
          r.key_code = code;
          r.key_down = 1'b0;
          r.repeat_enable = 1'($urandom_range(0, 1));
          r.repeat_suppress = 1'($urandom_range(0, 1));
          send_req(r, 1'b0, '0);
          sent++;
        end
      end
    end
  endtask

  // receiver stall pattern
  initial begin
    int left;
    left = 0;
    forever begin
      @(negedge clk);
      if (left > 0) begin
        out_stall <= 1'b1;
        left--;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 99) < rx_stall_pct) begin
          left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 30);
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: fire %b held %b key_mapped %b",
                   out_data.fire, out_data.held, out_data.key_mapped);
        end
      end else begin
        want = pending_results.pop_front();
        if (out_data.fire !== want.fire || out_data.held !== want.held ||
            out_data.key_mapped !== want.key_mapped) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch: expected fire %b held %b key_mapped %b, got %b %b %b",
                     want.fire, want.held, want.key_mapped,
                     out_data.fire, out_data.held, out_data.key_mapped);
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      held_st[i] = 1'b0;
      latch_st[i] = 1'b0;
      cnt_st[i] = '0;
    end
    limit_st = LIMIT_RESET;
    // req_type, key_code, key_down, repeat_enable, repeat_suppress | typed | fire, held, mapped
    dir_rows = '{
      '{'{REQ_QUERY,  KEY_A,           1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{REQ_UPDATE, 8'h00,           1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, 8'hFF,           1'b1, 1'b0, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_QUERY,  8'hFF,           1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, KEY_A,           1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, KEY_A,           1'b1, 1'b1, 1'b0}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_QUERY,  KEY_A,           1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, KEY_A,           1'b0, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{REQ_UPDATE, KEY_Z,           1'b1, 1'b0, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, KEY_Z,           1'b1, 1'b0, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, KEY_Z,           1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{REQ_UPDATE, KEY_ARROW_FIRST, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, KEY_ARROW_FIRST, 1'b1, 1'b1, 1'b1}, 1'b0, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, KEY_ARROW_LAST,  1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, KEY_SPACE,       1'b1, 1'b1, 1'b0}, 1'b1, '{1'b1, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, KEY_ENTER,       1'b1, 1'b1, 1'b1}, 1'b1, '{1'b1, 1'b1, 1'b1}},
      '{'{REQ_QUERY,  KEY_ENTER,       1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 1'b1, 1'b1}},
      '{'{REQ_UPDATE, 8'h24,           1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, 8'h29,           1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, 8'h40,           1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, 8'h5B,           1'b1, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, 8'h0C,           1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, 8'hC1,           1'b1, 1'b1, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{REQ_UPDATE, 8'h26,           1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{REQ_QUERY,  8'h26,           1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_gap_pct = 20;
    rx_stall_pct = 20;
    foreach (dir_rows[i]) begin
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end

    load_repeat_limit(8'd0);
    tx_gap_pct = 0;
    rx_stall_pct = 0;
    run_random(300, 0);

    // long hold at limit 254, the highest limit the saturating counter can exceed, so the counter runs past it
    load_repeat_limit(8'd254);
    tx_gap_pct = 20;
    rx_stall_pct = 20;
    run_random(400, 300);

    load_repeat_limit(8'd1);
    tx_gap_pct = 40;
    rx_stall_pct = 10;
    run_random(300, 0);

    load_repeat_limit(8'd3);
    tx_gap_pct = 10;
    rx_stall_pct = 40;
    run_random(300, 0);

    load_repeat_limit(LIMIT_BITS'($urandom_range(0, 254)));
    tx_gap_pct = 25;
    rx_stall_pct = 25;
    run_random(300, 0);

    load_repeat_limit(LIMIT_BITS'($urandom_range(2, 20)));
    tx_gap_pct = 5;
    rx_stall_pct = 5;
    run_random(200, 0);

    drain_results();
    if (pending_results.size() != 0) err_cnt++;
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/kpert_pkg.sv
src/kpert_entry_update.sv
src/key_press_edge_repeat_table.sv
tb/tb.sv
